[hdl/bzr_pkg.sv]
// ----------------------------------------------------------------------------
// bzr_pkg: shared constants and types of the bilinear zoom resampler
// Store geometry, field widths and the store access bundles.
// ----------------------------------------------------------------------------
package bzr_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int FRAC_BITS   = 8;

  localparam int PIX_W       = 8;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef logic [ADDR_W-1:0] store_addr_t;
  typedef logic [PIX_W-1:0]  pix_t;

  typedef struct packed {
    logic        en;
    store_addr_t addr;
    pix_t        data;
  } store_wr_t;

  // four neighbour addresses: top row and bottom row, left and right column
  typedef struct packed {
    store_addr_t a00;
    store_addr_t a01;
    store_addr_t a10;
    store_addr_t a11;
  } store_rd_t;

  typedef struct packed {
    pix_t d00;
    pix_t d01;
    pix_t d10;
    pix_t d11;
  } store_data_t;

endpackage

[hdl/bilinear_zoom_resampler_top.sv]
// ----------------------------------------------------------------------------
// bilinear_zoom_resampler_top: zoom and pan resampler for one 8-bit plane
// Throughput: one request per cycle unless out_stall backs up the pipeline;
// the frame store reads all four neighbours together from its two copies,
// so loads and renders mix freely.
// Reset clears the pipeline and the registers; store contents stay undefined
// until loaded, with no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_zoom_resampler_top import bzr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [9:0]  column,
  input  logic [9:0]  row,
  input  logic [7:0]  pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FIELD_W  = 10;
  localparam int ORIGIN_W = 26;
  localparam int STEP_W   = 21;
  localparam int LIMIT_W  = 10;
  localparam int PROD_W   = FIELD_W + STEP_W;
  localparam int POS_W    = PROD_W + 1;
  localparam int POS_FRAC = 16;
  localparam int IX_W     = POS_W - POS_FRAC;
  localparam int SC_W     = $clog2(MAX_WIDTH);
  localparam int SR_W     = $clog2(MAX_HEIGHT);
  localparam int ONE_WEIGHT = 1 << FRAC_BITS;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [2:0] REG_NEAREST_MODE = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd2;
  localparam logic [2:0] REG_STEP_X       = 3'd3;
  localparam logic [2:0] REG_STEP_Y       = 3'd4;
  localparam logic [2:0] REG_LAST_COLUMN  = 3'd5;
  localparam logic [2:0] REG_LAST_ROW     = 3'd6;

  typedef logic [FRAC_BITS-1:0] frac_t;

  function automatic pix_t blend(input pix_t a, input pix_t b, input frac_t f);
    logic [2*PIX_W:0] s;
    s = (2*PIX_W+1)'(a) * (2*PIX_W+1)'(ONE_WEIGHT - int'(f))
      + (2*PIX_W+1)'(b) * (2*PIX_W+1)'(f);
    return s[FRAC_BITS +: PIX_W];
  endfunction

  function automatic logic [SC_W-1:0] sat_col(input logic [IX_W:0] v);
    return (v > (IX_W+1)'(MAX_WIDTH - 1)) ? SC_W'(MAX_WIDTH - 1) : v[SC_W-1:0];
  endfunction

  function automatic logic [SR_W-1:0] sat_row(input logic [IX_W:0] v);
    return (v > (IX_W+1)'(MAX_HEIGHT - 1)) ? SR_W'(MAX_HEIGHT - 1) : v[SR_W-1:0];
  endfunction

  function automatic store_addr_t addr_of(input logic [SR_W-1:0] r,
                                          input logic [SC_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
  endfunction

  function automatic logic [IX_W:0] lim_next(input logic [IX_W-1:0] i,
                                             input logic [LIMIT_W-1:0] last);
    logic [IX_W:0] n;
    n = (IX_W+1)'(i) + (IX_W+1)'(1);
    return (n > (IX_W+1)'(last)) ? (IX_W+1)'(last) : n;
  endfunction

  // configuration registers
  logic                nearest_mode;
  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;
  logic [STEP_W-1:0]   step_x;
  logic [STEP_W-1:0]   step_y;
  logic [LIMIT_W-1:0]  last_column;
  logic [LIMIT_W-1:0]  last_row;

  logic       cfg_write;
  logic [2:0] cfg_reg;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_reg   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      nearest_mode <= 1'b0;
      origin_x     <= '0;
      origin_y     <= '0;
      step_x       <= STEP_W'(65536);
      step_y       <= STEP_W'(65536);
      last_column  <= LIMIT_W'(1023);
      last_row     <= LIMIT_W'(1023);
    end else if (cfg_write) begin
      unique case (cfg_reg)
        REG_NEAREST_MODE: nearest_mode <= pwdata[0];
        REG_ORIGIN_X:     origin_x     <= pwdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y:     origin_y     <= pwdata[ORIGIN_W-1:0];
        REG_STEP_X:       step_x       <= pwdata[STEP_W-1:0];
        REG_STEP_Y:       step_y       <= pwdata[STEP_W-1:0];
        REG_LAST_COLUMN:  last_column  <= pwdata[LIMIT_W-1:0];
        REG_LAST_ROW:     last_row     <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_NEAREST_MODE: prdata = 32'(nearest_mode);
      REG_ORIGIN_X:     prdata = 32'(origin_x);
      REG_ORIGIN_Y:     prdata = 32'(origin_y);
      REG_STEP_X:       prdata = 32'(step_x);
      REG_STEP_Y:       prdata = 32'(step_y);
      REG_LAST_COLUMN:  prdata = 32'(last_column);
      REG_LAST_ROW:     prdata = 32'(last_row);
      default:          prdata = '0;
    endcase
  end

  // pipeline: 1 products, 2 positions, 3 addresses, 4 store read,
  // 5 horizontal lerps, 6 vertical lerp / output register
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6     = !v6 || !out_stall;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  logic               op1, op2, op3;
  logic [FIELD_W-1:0] col1, col2, row1, row2;
  pix_t               pix1, pix2;
  logic [PROD_W-1:0]  prod_x1, prod_y1;
  logic [POS_W-1:0]   px2, py2;
  store_rd_t          rd3;
  store_wr_t          wr3;
  frac_t              fx3, fy3, fx4, fy4, fy5;
  pix_t               top5, bot5, near5, pix6;
  store_data_t        rd_data;

  logic [IX_W-1:0] ix2, iy2;
  logic [SC_W-1:0] c0, c1;
  logic [SR_W-1:0] r0, r1;

  assign ix2 = px2[POS_W-1:POS_FRAC];
  assign iy2 = py2[POS_W-1:POS_FRAC];
  assign c0  = sat_col({1'b0, ix2});
  assign r0  = sat_row({1'b0, iy2});
  assign c1  = sat_col(lim_next(ix2, last_column));
  assign r1  = sat_row(lim_next(iy2, last_row));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      // loads end at the store
      if (rdy4) v4 <= v3 && (op3 == OP_RENDER);
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1     <= opcode;
      col1    <= column;
      row1    <= row;
      pix1    <= pixel_in;
      prod_x1 <= PROD_W'(column) * PROD_W'(step_x);
      prod_y1 <= PROD_W'(row) * PROD_W'(step_y);
    end
    if (rdy2) begin
      op2  <= op1;
      col2 <= col1;
      row2 <= row1;
      pix2 <= pix1;
      px2  <= POS_W'(origin_x) + POS_W'(prod_x1);
      py2  <= POS_W'(origin_y) + POS_W'(prod_y1);
    end
    if (rdy3) begin
      op3      <= op2;
      rd3.a00  <= addr_of(r0, c0);
      rd3.a01  <= addr_of(r0, c1);
      rd3.a10  <= addr_of(r1, c0);
      rd3.a11  <= addr_of(r1, c1);
      fx3      <= px2[POS_FRAC-1 -: FRAC_BITS];
      fy3      <= py2[POS_FRAC-1 -: FRAC_BITS];
      // writes outside the store are dropped
      wr3.en   <= (op2 == OP_LOAD) && (int'(col2) < MAX_WIDTH) && (int'(row2) < MAX_HEIGHT);
      wr3.addr <= ADDR_W'(row2) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col2);
      wr3.data <= pix2;
    end
    if (rdy4) begin
      fx4 <= fx3;
      fy4 <= fy3;
    end
    if (rdy5) begin
      top5  <= blend(rd_data.d00, rd_data.d01, fx4);
      bot5  <= blend(rd_data.d10, rd_data.d11, fx4);
      near5 <= rd_data.d00;
      fy5   <= fy4;
    end
    if (rdy6) begin
      pix6 <= nearest_mode ? near5 : blend(top5, bot5, fy5);
    end
  end

  // loads and reads share the store stage, so requests stay in order
  store_wr_t store_wr;

  always_comb begin
    store_wr    = wr3;
    store_wr.en = wr3.en && v3 && rdy4;
  end

  bzr_store u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_en   (rdy4),
    .rd      (rd3),
    .rd_data (rd_data)
  );

  assign out_valid = v6;
  assign pixel_out = pix6;

endmodule

[hdl/bzr_store.sv]
// ----------------------------------------------------------------------------
// bzr_store: source frame store
// Two copies of the plane, both written on every load request. The top copy
// serves the upper neighbour pair and the bottom copy the lower pair, each
// read at two addresses per cycle while rd_en is high, with registered read data.
// ----------------------------------------------------------------------------
module bzr_store import bzr_pkg::*; (
  input  logic        clk,
  input  store_wr_t   wr,
  input  logic        rd_en,
  input  store_rd_t   rd,
  output store_data_t rd_data
);

  pix_t bank_top [STORE_DEPTH];
  pix_t bank_bot [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      bank_top[wr.addr] <= wr.data;
      bank_bot[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.d00 <= bank_top[rd.a00];
      rd_data.d01 <= bank_top[rd.a01];
      rd_data.d10 <= bank_bot[rd.a10];
      rd_data.d11 <= bank_bot[rd.a11];
    end
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the bilinear zoom resampler
// Loads source pixels and renders window pixels under many register settings,
// predicting every returned pixel from a shadow copy of the frame store and
// registers. Renders only touch store entries that were loaded before.
// ----------------------------------------------------------------------------
module tb_top import bzr_pkg::*;;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_NEAREST_MODE,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_STEP_X,
    REG_STEP_Y,
    REG_LAST_COLUMN,
    REG_LAST_ROW
  } reg_index_e;

  typedef struct {
    logic [9:0] c0;
    logic [9:0] c1;
    logic [9:0] r0;
    logic [9:0] r1;
    logic [7:0] fx;
    logic [7:0] fy;
  } src_pos_t;

  localparam int PIPE_LATENCY  = 5;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic [25:0] ORIGIN_MAX = 26'h3FFFFFF;
  localparam int STEP_MAX      = 1048576;
  localparam int STEP_ONE      = 65536;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = OP_LOAD;
  logic [9:0]  column = '0;
  logic [9:0]  row = '0;
  logic [7:0]  pixel_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  pixel_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow registers and frame store
  logic        cfg_nearest = 1'b0;
  logic [25:0] cfg_origin_x = '0;
  logic [25:0] cfg_origin_y = '0;
  logic [20:0] cfg_step_x = 21'(STEP_ONE);
  logic [20:0] cfg_step_y = 21'(STEP_ONE);
  logic [9:0]  cfg_last_column = 10'd1023;
  logic [9:0]  cfg_last_row = 10'd1023;
  logic [7:0]  src_plane [int unsigned];

  logic [7:0]  expected_pixels [$];
  int          error_count = 0;
  int          request_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  bilinear_zoom_resampler_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .column    (column),
    .row       (row),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d renders pending", $time, expected_pixels.size());
      $display("FAIL bilinear_zoom_resampler_top");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // compare each returned pixel with the oldest pending render
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel_out, expected none, actual %0d", $time, pixel_out);
        error_count++;
      end else begin
        if (pixel_out !== expected_pixels[0]) begin
          $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                   $time, expected_pixels[0], pixel_out);
          error_count++;
        end
        void'(expected_pixels.pop_front());
      end
    end
  end

  function automatic logic [9:0] clip_index(logic [63:0] v, int lim);
    return (v > 64'(lim)) ? 10'(lim) : v[9:0];
  endfunction

  function automatic src_pos_t locate(logic [9:0] col, logic [9:0] rw);
    logic [63:0] px;
    logic [63:0] py;
    logic [63:0] nx;
    logic [63:0] ny;
    src_pos_t    p;
    px = 64'(cfg_origin_x) + 64'(col) * 64'(cfg_step_x);
    py = 64'(cfg_origin_y) + 64'(rw) * 64'(cfg_step_y);
    p.fx = px[15:8];
    p.fy = py[15:8];
    p.c0 = clip_index(px >> 16, MAX_WIDTH - 1);
    p.r0 = clip_index(py >> 16, MAX_HEIGHT - 1);
    // right and lower neighbours stop at the configured last column and row
    nx = (px >> 16) + 64'd1;
    if (nx > 64'(cfg_last_column)) nx = 64'(cfg_last_column);
    ny = (py >> 16) + 64'd1;
    if (ny > 64'(cfg_last_row)) ny = 64'(cfg_last_row);
    p.c1 = clip_index(nx, MAX_WIDTH - 1);
    p.r1 = clip_index(ny, MAX_HEIGHT - 1);
    return p;
  endfunction

  function automatic logic [7:0] plane_at(logic [9:0] c, logic [9:0] r);
    return src_plane.exists({r, c}) ? src_plane[{r, c}] : 8'h00;
  endfunction

  function automatic logic [7:0] lerp8(logic [7:0] a, logic [7:0] b, logic [7:0] f);
    int acc;
    acc = int'(a) * (256 - int'(f)) + int'(b) * int'(f);
    return acc[15:8];
  endfunction

  function automatic logic [7:0] resample_pixel(logic [9:0] col, logic [9:0] rw);
    src_pos_t   p;
    logic [7:0] top;
    logic [7:0] bot;
    p = locate(col, rw);
    if (cfg_nearest) return plane_at(p.c0, p.r0);
    top = lerp8(plane_at(p.c0, p.r0), plane_at(p.c1, p.r0), p.fx);
    bot = lerp8(plane_at(p.c0, p.r1), plane_at(p.c1, p.r1), p.fx);
    return lerp8(top, bot, p.fy);
  endfunction

  task automatic send_request(op_e op, logic [9:0] col, logic [9:0] rw, logic [7:0] pix);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    column   <= col;
    row      <= rw;
    pixel_in <= pix;
    do @(posedge clk); while (in_stall);
    request_count++;
    if (op == OP_LOAD) begin
      src_plane[{rw, col}] = pix;
    end else begin
      expected_pixels.push_back(resample_pixel(col, rw));
    end
  endtask

  // load any neighbour the render would fetch that was never loaded
  task automatic render_pixel(logic [9:0] col, logic [9:0] rw);
    src_pos_t p;
    p = locate(col, rw);
    if (!src_plane.exists({p.r0, p.c0})) send_request(OP_LOAD, p.c0, p.r0, 8'($urandom));
    if (!src_plane.exists({p.r0, p.c1})) send_request(OP_LOAD, p.c1, p.r0, 8'($urandom));
    if (!src_plane.exists({p.r1, p.c0})) send_request(OP_LOAD, p.c0, p.r1, 8'($urandom));
    if (!src_plane.exists({p.r1, p.c1})) send_request(OP_LOAD, p.c1, p.r1, 8'($urandom));
    send_request(OP_RENDER, col, rw, 8'($urandom));
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(reg_index_e idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_NEAREST_MODE: cfg_nearest     = value[0];
      REG_ORIGIN_X:     cfg_origin_x    = value[25:0];
      REG_ORIGIN_Y:     cfg_origin_y    = value[25:0];
      REG_STEP_X:       cfg_step_x      = value[20:0];
      REG_STEP_Y:       cfg_step_y      = value[20:0];
      REG_LAST_COLUMN:  cfg_last_column = value[9:0];
      REG_LAST_ROW:     cfg_last_row    = value[9:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'(ORIGIN_MAX);
      2: return $urandom_range(0, 32'(ORIGIN_MAX));
      default: return $urandom_range(0, 32'h3FFFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'(STEP_MAX);
      2: return 32'(STEP_ONE);
      3, 4: return $urandom_range(0, STEP_MAX);
      default: return $urandom_range(0, 32'h20000);
    endcase
  endfunction

  function automatic logic [31:0] pick_last();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd1023;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  // reset settings: bilinear, unit step, corners and the right and lower clamp
  task automatic test_default_window();
    send_request(OP_LOAD, 10'd0, 10'd0, 8'd255);
    send_request(OP_LOAD, 10'd1, 10'd0, 8'd0);
    send_request(OP_LOAD, 10'd0, 10'd1, 8'd0);
    send_request(OP_LOAD, 10'd1, 10'd1, 8'd255);
    render_pixel(10'd0, 10'd0);
    render_pixel(10'd1023, 10'd1023);
    render_pixel(10'd1023, 10'd0);
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    // nearest mode with the window pinned at the far corner
    write_register(REG_NEAREST_MODE, 32'd1);
    write_register(REG_ORIGIN_X, 32'(ORIGIN_MAX));
    write_register(REG_ORIGIN_Y, 32'(ORIGIN_MAX));
    write_register(REG_STEP_X, 32'd0);
    write_register(REG_STEP_Y, 32'd0);
    render_pixel(10'd1023, 10'd1023);
    render_pixel(10'd0, 10'd0);
    drain_pipeline();
    // half-pixel origin, a step of 16 pixels, neighbour limit at column and row 0
    write_register(REG_NEAREST_MODE, 32'd0);
    write_register(REG_ORIGIN_X, 32'h8000);
    write_register(REG_ORIGIN_Y, 32'h8000);
    write_register(REG_STEP_X, 32'(STEP_MAX));
    write_register(REG_STEP_Y, 32'(STEP_MAX));
    write_register(REG_LAST_COLUMN, 32'd0);
    write_register(REG_LAST_ROW, 32'd0);
    render_pixel(10'd0, 10'd0);
    render_pixel(10'd1, 10'd1);
    render_pixel(10'd1023, 10'd1023);
    drain_pipeline();
  endtask

  task automatic test_random_traffic(int send_pct, int stall_pct, int n_items);
    int       limit;
    int       kind;
    src_pos_t p;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < 4; seg++) begin
      drain_pipeline();
      write_register(REG_NEAREST_MODE, 32'($urandom_range(0, 9) < 3));
      write_register(REG_ORIGIN_X, pick_origin());
      write_register(REG_ORIGIN_Y, pick_origin());
      write_register(REG_STEP_X, pick_step());
      write_register(REG_STEP_Y, pick_step());
      write_register(REG_LAST_COLUMN, pick_last());
      write_register(REG_LAST_ROW, pick_last());
      limit = request_count + n_items / 4;
      while (request_count < limit) begin
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          if ($urandom_range(0, 1) != 0) begin
            render_pixel(10'($urandom_range(0, 31)), 10'($urandom_range(0, 31)));
          end else begin
            render_pixel(10'($urandom), 10'($urandom));
          end
        end else if (kind < 85) begin
          // overwrite pixels that renders of this window are likely to fetch
          p = locate(10'($urandom_range(0, 31)), 10'($urandom_range(0, 31)));
          send_request(OP_LOAD, $urandom_range(0, 1) ? p.c1 : p.c0,
                       $urandom_range(0, 1) ? p.r1 : p.r0, 8'($urandom));
        end else begin
          send_request(OP_LOAD, 10'($urandom), 10'($urandom), 8'($urandom));
        end
      end
    end
    drain_pipeline();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_window();
    test_register_extremes();
    test_random_traffic(30, 75, 200);
    test_random_traffic(75, 30, 200);
    test_random_traffic(0, 0, 200);
    if (error_count == 0) begin
      $display("PASS bilinear_zoom_resampler_top");
    end else begin
      $display("FAIL bilinear_zoom_resampler_top");
    end
    $finish;
  end

endmodule
